// File: hdl/lawsort_pkg.sv
// shared types and constants for the linear array window sort
// no dependencies
package lawsort_pkg;
	localparam int ValueWidth = 32;
	localparam int PtrWidth   = 3;
	localparam int QueueDepth = 4;

	typedef logic signed [ValueWidth-1:0] value_t;

	typedef struct packed {
		value_t value;
		logic   last;
	} beat_t;

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_SORT = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	function automatic logic gt_s(input value_t a, input value_t b);
		return a > b;
	endfunction
endpackage

// File: hdl/lawsort_if.sv
// valid/ready channel carrying one value and a last marker
// depends on lawsort_pkg
interface lawsort_if import lawsort_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t value;
	logic   last;

	modport source (output valid, value, last, input ready);
	modport sink (input valid, value, last, output ready);
endinterface

// File: hdl/lawsort_queue.sv
// front part: short queue between intake and the sort engine
// depends on lawsort_pkg
module lawsort_queue import lawsort_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  beat_t in_beat,
	output logic  out_valid,
	input  logic  out_ready,
	output beat_t out_beat
);
	beat_t                buf_q [QueueDepth];
	logic [PtrWidth-1:0]  wr_q, rd_q;
	logic                 push, pop;

	assign in_ready  = (wr_q - rd_q) != PtrWidth'(QueueDepth);
	assign out_valid = wr_q != rd_q;
	assign out_beat  = buf_q[rd_q[PtrWidth-2:0]];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q[PtrWidth-2:0]] <= in_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
		end
	end
endmodule

// File: hdl/lawsort_engine.sv
// back part: value array, round sequencer with window sorters, emitter
// depends on lawsort_pkg
module lawsort_engine import lawsort_pkg::*; #(
	parameter int MAX_ITEMS = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  beat_t  in_beat,
	output logic   out_valid,
	input  logic   out_ready,
	output value_t out_value,
	output logic   out_final,
	output state_t state
);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	value_t         arr_q [MAX_ITEMS];
	value_t         nxt   [MAX_ITEMS];
	logic [CW-1:0]  cnt_q, rnd_q, idx_q;
	logic [1:0]     ph_q;
	state_t         st_q;

	assign state     = st_q;
	assign in_ready  = st_q == ST_LOAD;
	assign out_valid = st_q == ST_EMIT;
	assign out_value = arr_q[idx_q[IW-1:0]];
	assign out_final = (idx_q + 1'b1) == cnt_q;

	// one round: windows whose middle satisfies (i+r) mod 3 == 1; ph_q tracks r mod 3
	always_comb begin
		logic [2:0] s;
		logic [1:0] m;
		value_t a, b, c, t;
		logic hasl, hasr;
		for (int i = 0; i < MAX_ITEMS; i++) nxt[i] = arr_q[i];
		for (int i = 0; i < MAX_ITEMS; i++) begin
			s = 3'(i % 3) + {1'b0, ph_q};
			m = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
			hasl = i > 0;
			hasr = (i + 1) < int'(cnt_q);
			b = arr_q[i];
			a = b;
			c = b;
			t = b;
			if (m == 2'd1 && i < int'(cnt_q)) begin
				a = hasl ? arr_q[(i + MAX_ITEMS - 1) % MAX_ITEMS] : b;
				c = hasr ? arr_q[(i+1) % MAX_ITEMS] : b;
				if (hasl && gt_s(a, b)) begin t = a; a = b; b = t; end
				if (hasr && gt_s(b, c)) begin t = b; b = c; c = t; end
				if (hasl && gt_s(a, b)) begin t = a; a = b; b = t; end
				if (hasl) nxt[(i + MAX_ITEMS - 1) % MAX_ITEMS] = a;
				nxt[i] = b;
				if (hasr) nxt[(i+1) % MAX_ITEMS] = c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_LOAD && in_valid && cnt_q < CW'(MAX_ITEMS)) begin
			arr_q[cnt_q[IW-1:0]] <= in_beat.value;
		end else if (st_q == ST_SORT) begin
			for (int i = 0; i < MAX_ITEMS; i++) arr_q[i] <= nxt[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_LOAD;
			cnt_q <= '0;
			rnd_q <= '0;
			idx_q <= '0;
			ph_q  <= '0;
		end else begin
			case (st_q)
				ST_LOAD: begin
					if (in_valid) begin
						logic [CW-1:0] n;
						n = (cnt_q < CW'(MAX_ITEMS)) ? cnt_q + 1'b1 : cnt_q;
						cnt_q <= n;
						rnd_q <= '0;
						ph_q  <= '0;
						idx_q <= '0;
						if (in_beat.last) st_q <= (n > CW'(1)) ? ST_SORT : ST_EMIT;
					end
				end
				ST_SORT: begin
					rnd_q <= rnd_q + 1'b1;
					ph_q  <= (ph_q == 2'd2) ? 2'd0 : ph_q + 1'b1;
					if (rnd_q + CW'(2) >= cnt_q) st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 1'b1;
						if (out_final) begin
							st_q  <= ST_LOAD;
							cnt_q <= '0;
						end
					end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// File: hdl/linear_array_window_sort.sv
// Sorts a set of up to MAX_ITEMS signed values ended by a last beat. After the last
// beat of a set with n > 1 values the engine runs n-1 rounds (all windows of a round
// sort in parallel), then streams n results one per cycle while out_ready is high,
// the final one marked. A four-entry queue keeps accepting input while a set is
// sorted or emitted, until the queue is full.
// depends on lawsort_pkg, lawsort_if, lawsort_queue, lawsort_engine
module linear_array_window_sort import lawsort_pkg::*; #(
	parameter int MAX_ITEMS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	lawsort_if.sink   in_ch,
	lawsort_if.source out_ch
);
	beat_t  in_beat, q_beat;
	logic   q_valid, q_ready;
	state_t state;

	assign in_beat = '{value: in_ch.value, last: in_ch.last};

	lawsort_queue u_queue (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_beat,
		.out_valid(q_valid), .out_ready(q_ready), .out_beat(q_beat)
	);

	lawsort_engine #(.MAX_ITEMS(MAX_ITEMS)) u_engine (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(q_ready), .in_beat(q_beat),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_value(out_ch.value), .out_final(out_ch.last), .state
	);

	a_no_take_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !q_ready) else $error("engine took input while emitting");
	a_load_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.last |=> state == ST_LOAD)
		else $error("engine not back to load after final beat");
	a_emit_from_sort_or_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(state) == ST_SORT || $past(state) == ST_LOAD)
		else $error("bad entry to emit");
endmodule
